>>> hdl/bb3_pkg.sv
// bb3_pkg: shared types and constants for the 3x3 rgb box blur
// no dependencies; imported by every module of the block
package bb3_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       frame_end;
  } out_t;

  typedef struct packed {
    logic primed;
    logic col_first;
    logic col_last;
    logic row_first;
    logic row_last;
    logic last;
  } ctl_t;

  typedef logic [2:0][2:0][23:0] win_t;

endpackage

>>> hdl/bb3_line_win.sv
// bb3_line_win: two line stores and the 3x3 pixel window
// depends on bb3_pkg
module bb3_line_win import bb3_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_acc,
  input  logic [CW-1:0] wr_col,
  input  logic [23:0]   pix,
  input  ctl_t          ctl_in,
  output logic          win_valid,
  output ctl_t          win_ctl,
  output win_t          win
);

  logic [23:0]   up_mem  [MAX_WIDTH];
  logic [23:0]   mid_mem [MAX_WIDTH];
  logic [23:0]   up_rd_r;
  logic [23:0]   mid_rd_r;
  logic [23:0]   a_pix_r;
  logic [CW-1:0] a_col_r;
  ctl_t          a_ctl_r;
  logic          a_valid_r;
  logic          win_valid_r;
  ctl_t          win_ctl_r;
  win_t          win_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mid_mem[wr_col] <= pix;
      mid_rd_r        <= mid_mem[wr_col];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      up_rd_r <= up_mem[wr_col];
    end
    if (en && a_valid_r) begin
      up_mem[a_col_r] <= mid_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_pix_r <= pix;
      a_col_r <= wr_col;
      a_ctl_r <= ctl_in;
    end
    if (en && a_valid_r) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= up_rd_r;
      win_r[1][2] <= mid_rd_r;
      win_r[2][2] <= a_pix_r;
      win_ctl_r   <= a_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      win_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r   <= in_acc;
      win_valid_r <= a_valid_r;
    end
  end

  assign win_valid = win_valid_r;
  assign win_ctl   = win_ctl_r;
  assign win       = win_r;

endmodule

>>> hdl/bb3_mean.sv
// bb3_mean: masked neighborhood sums and division by 4, 6 or 9
// depends on bb3_pkg
module bb3_mean import bb3_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic win_valid,
  input  ctl_t win_ctl,
  input  win_t win,
  output logic out_valid,
  output out_t out_data
);

  localparam logic [1:0] DIV4 = 2'd0;
  localparam logic [1:0] DIV6 = 2'd1;
  localparam logic [1:0] DIV9 = 2'd2;

  localparam logic [13:0] RECIP6 = 14'd10923;
  localparam logic [13:0] RECIP9 = 14'd7282;

  logic [2:0][11:0] sum;
  logic [1:0]       div_code;
  logic [2:0][11:0] c_sum_r;
  logic [1:0]       c_div_r;
  logic             c_last_r;
  logic             c_valid_r;
  logic [2:0][7:0]  quo;
  logic             out_valid_r;
  out_t             out_r;

  always_comb begin
    logic row_edge;
    logic col_edge;
    logic use_tap;
    row_edge = win_ctl.row_first || win_ctl.row_last;
    col_edge = win_ctl.col_first || win_ctl.col_last;
    sum = '0;
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          use_tap = (r != 0 || !win_ctl.row_first) && (r != 2 || !win_ctl.row_last) &&
                    (c != 0 || !win_ctl.col_first) && (c != 2 || !win_ctl.col_last);
          if (use_tap) begin
            sum[ch] = sum[ch] + 12'(win[r][c][8*ch +: 8]);
          end
        end
      end
    end
    if (row_edge && col_edge) begin
      div_code = DIV4;
    end else if (row_edge || col_edge) begin
      div_code = DIV6;
    end else begin
      div_code = DIV9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sum_r  <= sum;
      c_div_r  <= div_code;
      c_last_r <= win_ctl.last;
    end
  end

  always_comb begin
    logic [25:0] prod;
    quo = '0;
    for (int ch = 0; ch < 3; ch++) begin
      case (c_div_r)
        DIV4: begin
          prod    = '0;
          quo[ch] = c_sum_r[ch][9:2];
        end
        DIV6: begin
          prod    = 26'(c_sum_r[ch]) * 26'(RECIP6);
          quo[ch] = prod[23:16];
        end
        default: begin
          prod    = 26'(c_sum_r[ch]) * 26'(RECIP9);
          quo[ch] = prod[23:16];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.blue_out  <= quo[0];
      out_r.green_out <= quo[1];
      out_r.red_out   <= quo[2];
      out_r.frame_end <= c_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r   <= win_valid && win_ctl.primed;
      out_valid_r <= c_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hdl/box_blur_3x3_rgb.sv
// box_blur_3x3_rgb: streaming 3x3 mean filter on 24-bit bgr pixels
// depends on bb3_pkg, bb3_line_win and bb3_mean
//
// usage
//   pixels enter in raster order on in_valid/in_ready/in_data; cmd set marks
//   a drain transaction that carries no pixel. each frame needs width+1 drain
//   transactions after its last pixel to flush the tail.
//   results leave on out_valid/out_ready/out_data; frame_end marks the last
//   pixel of a frame, after which the next transaction starts a new frame.
//   the result for pixel (r,c) comes with input transaction (r+1)*width+c+1;
//   out_valid rises once that transaction has passed the store read, window,
//   sum and divide registers.
//   throughput: one transaction per cycle while the pipeline is not stalled;
//   each line store is read and written once per transaction.
//   cfg_we writes frame_width (index 0) or frame_height (index 1) and
//   restarts the frame; write only while the pipeline is empty.
//   reset: sizes return to 640x480, counters to zero, pipeline empties;
//   the line stores keep their contents.
//   stall: when out_ready is low with a result held, the whole pipeline
//   freezes and in_ready drops in the same cycle.
module box_blur_3x3_rgb import bb3_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CAP = (MAX_WIDTH / 4) * 4;

  logic [10:0]   frame_width_r;
  logic [15:0]   frame_height_r;
  logic [10:0]   wmask;
  logic [15:0]   hmask;
  logic [CW-1:0] w_m1;
  logic [15:0]   h_m1;

  logic [CW-1:0] ic_r, ic_nxt;
  logic [15:0]   ir_r, ir_nxt;
  logic [CW-1:0] oc_r, oc_nxt;
  logic [15:0]   orow_r, orow_nxt;

  logic          en;
  logic          in_acc;
  logic          mean_valid;
  ctl_t          ctl;
  logic [23:0]   pix;
  logic          win_valid;
  ctl_t          win_ctl;
  win_t          win;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[10:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    wmask = frame_width_r & 11'h7FC;
    if (wmask < 11'd4) begin
      wmask = 11'd4;
    end
    if (int'(wmask) > CAP) begin
      w_m1 = CW'(CAP - 1);
    end else begin
      w_m1 = CW'(wmask - 11'd1);
    end
    hmask = frame_height_r & 16'hFFFC;
    if (hmask < 16'd4) begin
      hmask = 16'd4;
    end
    h_m1 = hmask - 16'd1;
  end

  assign en     = !mean_valid || out_ready;
  assign in_ready = en;
  assign in_acc = in_valid && en;

  always_comb begin
    ctl.primed    = (ir_r >= 16'd2) || (ir_r == 16'd1 && ic_r != '0);
    ctl.col_first = (oc_r == '0);
    ctl.col_last  = (oc_r >= w_m1);
    ctl.row_first = (orow_r == 16'd0);
    ctl.row_last  = (orow_r >= h_m1);
    ctl.last      = ctl.primed && ctl.col_last && ctl.row_last;

    if (in_data.cmd == CMD_PIXEL && ir_r <= h_m1) begin
      pix = {in_data.red_in, in_data.green_in, in_data.blue_in};
    end else begin
      pix = '0;
    end

    if (ic_r >= w_m1) begin
      ic_nxt = '0;
      ir_nxt = ir_r + 16'd1;
    end else begin
      ic_nxt = ic_r + CW'(1);
      ir_nxt = ir_r;
    end
    oc_nxt   = oc_r;
    orow_nxt = orow_r;
    if (ctl.primed) begin
      if (oc_r >= w_m1) begin
        oc_nxt   = '0;
        orow_nxt = orow_r + 16'd1;
      end else begin
        oc_nxt = oc_r + CW'(1);
      end
    end
    if (ctl.last) begin
      ic_nxt   = '0;
      ir_nxt   = '0;
      oc_nxt   = '0;
      orow_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      ic_r   <= '0;
      ir_r   <= '0;
      oc_r   <= '0;
      orow_r <= '0;
    end else if (in_acc) begin
      ic_r   <= ic_nxt;
      ir_r   <= ir_nxt;
      oc_r   <= oc_nxt;
      orow_r <= orow_nxt;
    end
  end

  bb3_line_win #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_line_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_acc    (in_acc),
    .wr_col    (ic_r),
    .pix       (pix),
    .ctl_in    (ctl),
    .win_valid (win_valid),
    .win_ctl   (win_ctl),
    .win       (win)
  );

  bb3_mean u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .win_valid (win_valid),
    .win_ctl   (win_ctl),
    .win       (win),
    .out_valid (mean_valid),
    .out_data  (out_data)
  );

  assign out_valid = mean_valid;

endmodule

>>> bench/box_blur_3x3_rgb_tb.sv
`timescale 1ns / 100ps
// box_blur_3x3_rgb_tb: self-checking bench for the streaming 3x3 rgb box blur,
// random and directed pixel streams checked against an in-bench mean predictor
// depends on bb3_pkg and box_blur_3x3_rgb only
module box_blur_3x3_rgb_tb;
  import bb3_pkg::*;

  localparam int FLUSH_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1800;

  class blur_scoreboard;
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [23:0] upper_line [MAX_WIDTH_DEF];
    logic [23:0] middle_line [MAX_WIDTH_DEF];
    logic [23:0] window [3][3];
    int unsigned in_col, in_row, out_col, out_row;
    out_t expected_pixels [$];
    int errors;

    function new();
      width_reg = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      foreach (window[r, c]) window[r][c] = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function int unsigned frame_w();
      int unsigned w;
      w = int'(width_reg & 11'h7FC);
      if (w < 4) w = 4;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      return w;
    endfunction

    function int unsigned frame_h();
      int unsigned h;
      h = int'(height_reg & 16'hFFFC);
      if (h < 4) h = 4;
      return h;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_FRAME_WIDTH) width_reg = val[10:0];
      else if (idx == CFG_FRAME_HEIGHT) height_reg = val;
      restart();
    endfunction

    // shift the pixel through line stores and window, then average the
    // in-frame part of the window once the pipeline is primed
    function void note_input(in_t item);
      int unsigned w, h, ic, ir, oc, orow, r0, r1, c0, c1, n;
      int unsigned sum [3];
      logic [23:0] pix, top, mid;
      bit primed, last;
      out_t res;
      w = frame_w();
      h = frame_h();
      ic = in_col;
      ir = in_row;
      pix = '0;
      if (ic >= w) ic = w - 1;
      if (item.cmd == CMD_PIXEL && ir < h) pix = {item.red_in, item.green_in, item.blue_in};
      top = upper_line[ic];
      mid = middle_line[ic];
      upper_line[ic] = mid;
      middle_line[ic] = pix;
      for (int k = 0; k < 3; k++) begin
        window[k][0] = window[k][1];
        window[k][1] = window[k][2];
      end
      window[0][2] = top;
      window[1][2] = mid;
      window[2][2] = pix;
      primed = ir >= 2 || (ir == 1 && ic >= 1);
      ic++;
      if (ic >= w) begin
        ic = 0;
        ir++;
      end
      in_col = ic;
      in_row = ir;
      if (!primed) return;

      oc = out_col;
      orow = out_row;
      r0 = (orow == 0) ? 1 : 0;
      r1 = (orow >= h - 1) ? 1 : 2;
      c0 = (oc == 0) ? 1 : 0;
      c1 = (oc >= w - 1) ? 1 : 2;
      sum = '{0, 0, 0};
      for (int unsigned rr = r0; rr <= r1; rr++) begin
        for (int unsigned cc = c0; cc <= c1; cc++) begin
          sum[0] += window[rr][cc][7:0];
          sum[1] += window[rr][cc][15:8];
          sum[2] += window[rr][cc][23:16];
        end
      end
      // corner, edge and interior counts are 4, 6 and 9
      n = (r1 - r0 + 1) * (c1 - c0 + 1);
      res.blue_out = 8'(sum[0] / n);
      res.green_out = 8'(sum[1] / n);
      res.red_out = 8'(sum[2] / n);
      last = oc >= w - 1 && orow >= h - 1;
      res.frame_end = last;
      if (last) begin
        restart();
      end else begin
        oc++;
        if (oc >= w) begin
          oc = 0;
          orow++;
        end
        out_col = oc;
        out_row = orow;
      end
      expected_pixels.push_back(res);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected transaction, expected none got %h", $time, got);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      check_field("blue_out", want.blue_out, got.blue_out);
      check_field("green_out", want.green_out, got.green_out);
      check_field("red_out", want.red_out, got.red_out);
      check_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int gap_pct = 0;
  int stall_pct = 0;
  int random_sent = 0;
  blur_scoreboard sb = new();

  box_blur_3x3_rgb dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic in_t random_item(int drain_pct);
    in_t item;
    item.cmd = ($urandom_range(0, 99) < drain_pct) ? CMD_DRAIN : CMD_PIXEL;
    item.blue_in = 8'($urandom_range(0, 255));
    item.green_in = 8'($urandom_range(0, 255));
    item.red_in = 8'($urandom_range(0, 255));
    return item;
  endfunction

  task automatic send(input in_t item);
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(item);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    for (int n = 0; n < 200000 && sb.pending() != 0; n++) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] w_raw,
                           input logic [CFG_DATA_W-1:0] h_raw);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_FRAME_WIDTH;
    cfg_wdata <= w_raw;
    @(posedge clk);
    sb.set_reg(CFG_FRAME_WIDTH, w_raw);
    cfg_addr <= CFG_FRAME_HEIGHT;
    cfg_wdata <= h_raw;
    @(posedge clk);
    sb.set_reg(CFG_FRAME_HEIGHT, h_raw);
    cfg_we <= 1'b0;
  endtask

  // full frames with mostly drains in the tail, sometimes a short tail,
  // then optional loose transactions that leave a frame unfinished
  task automatic run_frames(input int frames, input int extra);
    int unsigned w, h, tail;
    w = sb.frame_w();
    h = sb.frame_h();
    repeat (frames) begin
      tail = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w + 1) : w + 1;
      repeat (w * h) send(random_item(10));
      repeat (tail) send(random_item(75));
      random_sent += w * h + tail;
    end
    repeat (extra) send(random_item(10));
    random_sent += extra;
  endtask

  initial begin
    in_t item;
    int phase;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // widest frame, cut short once the start of the first row is out
    set_frame(16'hFFFF, 16'd2);
    run_frames(0, 1060);
    settle();

    // 4x4 frame: saturated channels, drain inside, pixels past the last row
    set_frame(16'd3, 16'd5);
    for (int i = 0; i < 21; i++) begin
      item.cmd = (i == 6 || i >= 18) ? CMD_DRAIN : CMD_PIXEL;
      item.blue_in = i[0] ? 8'hFF : 8'h00;
      item.green_in = i[1] ? 8'hFF : 8'h00;
      item.red_in = (i >= 16) ? 8'hA5 : (i[2] ? 8'hFF : 8'h00);
      send(item);
    end
    random_sent += 21;
    settle();

    phase = 0;
    while (random_sent < RANDOM_ITEMS || phase < 4) begin
      case (phase % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 53;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 53;
        end
        default: begin
          gap_pct = 31;
          stall_pct = 31;
        end
      endcase
      if (phase == 1) begin
        // tallest frame, cut short by the next register write
        set_frame(16'($urandom_range(0, 40)), 16'hFFFF);
        run_frames(0, $urandom_range(60, 160));
      end else begin
        set_frame(16'($urandom_range(0, 28)), 16'($urandom_range(0, 13)));
        run_frames($urandom_range(1, 2),
                   ($urandom_range(0, 2) == 0) ? $urandom_range(1, 30) : 0);
      end
      settle();
      phase++;
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (sb.pending() != 0)
        $display("%0t: %0d expected transactions never arrived", $time, sb.pending());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
hdl/bb3_pkg.sv
hdl/bb3_line_win.sv
hdl/bb3_mean.sv
hdl/box_blur_3x3_rgb.sv
bench/box_blur_3x3_rgb_tb.sv
